/* sv/lrfe_pkg.sv */
// lrfe_pkg: shared types, constants and helper functions of the led ring effect engine
// depends on nothing; imported by every module of the block but the checker
package lrfe_pkg;

  localparam int MAX_LEDS   = 256;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // effect codes
  localparam logic [1:0] MODE_FIXED  = 2'd0;
  localparam logic [1:0] MODE_CHASER = 2'd1;
  localparam logic [1:0] MODE_PULSE  = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_MODE          = 3'd0;
  localparam logic [2:0] CFG_LED_COUNT     = 3'd1;
  localparam logic [2:0] CFG_SPOT_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_ROTATION_STEP = 3'd3;
  localparam logic [2:0] CFG_PULSE_RATE    = 3'd4;
  localparam logic [2:0] CFG_MAX_BRIGHT    = 3'd5;
  localparam logic [2:0] CFG_MIN_BRIGHT    = 3'd6;

  // register reset values
  localparam logic [1:0]  RST_MODE          = MODE_FIXED;
  localparam logic [8:0]  RST_LED_COUNT     = 9'd24;
  localparam logic [8:0]  RST_SPOT_WIDTH    = 9'd4;
  localparam logic [15:0] RST_ROTATION_STEP = 16'd524;
  localparam logic [23:0] RST_PULSE_RATE    = 24'd1678;
  localparam logic [7:0]  RST_MAX_BRIGHT    = 8'd255;
  localparam logic [7:0]  RST_MIN_BRIGHT    = 8'd0;

  localparam logic [7:0]  FULL_BRIGHT = 8'd255;

  localparam logic [7:0] QUARTER_SINE [65] = '{
      8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,  8'd50,  8'd56,
      8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,  8'd98,  8'd103, 8'd109, 8'd115,
      8'd120, 8'd126, 8'd131, 8'd136, 8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167,
      8'd171, 8'd176, 8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
      8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233, 8'd236, 8'd238,
      8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253,
      8'd254, 8'd254, 8'd255, 8'd255, 8'd255
  };

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  led_count;
    logic [8:0]  spot_width;
    logic [15:0] rotation_step;
    logic [23:0] pulse_rate;
    logic [7:0]  max_brightness;
    logic [7:0]  min_brightness;
  } lrfe_cfg_t;

  // one classified pixel with the brightness that applies to it
  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
  } lrfe_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHASE,
    ST_PMUL,
    ST_PDIV,
    ST_MOD,
    ST_PUSH
  } lrfe_state_t;

  // ring size clamped to 1..MAX_LEDS
  function automatic logic [8:0] ring_size(input logic [8:0] lc);
    logic [8:0] n;
    n = lc;
    if (lc == 9'd0) n = 9'd1;
    else if (lc > 9'(MAX_LEDS)) n = 9'(MAX_LEDS);
    return n;
  endfunction

  // raised sine, 0..255 over one turn of the 8-bit address
  function automatic logic [7:0] sine_rom(input logic [7:0] addr);
    logic [6:0] j;
    logic [6:0] k;
    logic [7:0] h;
    logic [8:0] t;
    j = addr[6:0];
    k = (j <= 7'd64) ? j : 7'(8'd128 - {1'b0, j});
    h = QUARTER_SINE[k];
    t = addr[7] ? (9'd255 - {1'b0, h}) : (9'd255 + {1'b0, h});
    return t[8:1];
  endfunction

  // floor(x/255) for x up to 255*255, reciprocal form
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x >> 8) + 17'd1;
    return s[15:8];
  endfunction

endpackage

/* sv/lrfe_front.sv */
// lrfe_front: accepts items, runs frame updates and classifies pixels into jobs
// depends on lrfe_pkg; feeds lrfe_fifo
module lrfe_front (
  input  logic              clk,
  input  logic              rst,
  input  lrfe_pkg::lrfe_cfg_t cfg,
  input  logic              push,
  output logic              full,
  input  logic              action,
  input  logic [31:0]       time_ms,
  input  logic [7:0]        pixel_index,
  input  logic [7:0]        red_in,
  input  logic [7:0]        green_in,
  input  logic [7:0]        blue_in,
  input  logic              q_full,
  output logic              q_push,
  output lrfe_pkg::lrfe_job_t q_job
);
  import lrfe_pkg::*;

  lrfe_state_t state, state_next;

  logic [15:0] rotation_phase;
  logic [7:0]  pixel_offset;
  logic [7:0]  frame_brightness;

  logic [7:0]  pulse_addr;
  logic [15:0] pulse_prod;
  logic        pulse_up;

  logic [8:0]  mod_sum;
  logic [8:0]  mod_rem;
  logic [3:0]  mod_cnt;
  logic [7:0]  hold_idx, hold_r, hold_g, hold_b;

  logic        accept;
  logic        is_chaser, is_pulse;
  logic [8:0]  n;
  logic [8:0]  sum;
  logic [9:0]  diff;
  logic        sum_lt, wrap_ok, fast;
  logic [8:0]  pos;
  logic [7:0]  bright_now;
  logic [47:0] tp;
  logic [24:0] ofs_prod;
  logic [7:0]  sine_val, dif;
  logic [7:0]  q;
  logic [9:0]  trial, rem_step;

  assign is_chaser = (cfg.mode == MODE_CHASER);
  assign is_pulse  = (cfg.mode == MODE_PULSE);
  assign n         = ring_size(cfg.led_count);
  assign accept    = push && !full;

  // rotated position, one wrap handled directly
  assign sum     = {1'b0, pixel_index} + {1'b0, pixel_offset};
  assign diff    = {1'b0, sum} - {1'b0, n};
  assign sum_lt  = sum < n;
  assign wrap_ok = !diff[9] && (diff[8:0] < n);
  assign fast    = sum_lt || wrap_ok;
  assign pos     = sum_lt ? sum : diff[8:0];

  always_comb begin
    case (cfg.mode)
      MODE_CHASER: bright_now = (pos < cfg.spot_width) ? cfg.max_brightness
                                                       : cfg.min_brightness;
      MODE_PULSE:  bright_now = frame_brightness;
      default:     bright_now = FULL_BRIGHT;
    endcase
  end

  assign tp       = {24'd0, time_ms[23:0]} * {24'd0, cfg.pulse_rate};
  assign ofs_prod = {9'd0, rotation_phase} * {16'd0, n};
  assign sine_val = sine_rom(pulse_addr);
  assign dif      = (cfg.max_brightness >= cfg.min_brightness)
                  ? (cfg.max_brightness - cfg.min_brightness)
                  : (cfg.min_brightness - cfg.max_brightness);
  assign q        = div255(pulse_prod);

  // one restoring step of the slow modulo
  assign trial    = {mod_rem, mod_sum[8]};
  assign rem_step = (trial >= {1'b0, n}) ? (trial - {1'b0, n}) : trial;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!action) begin
            if (is_chaser) state_next = ST_CHASE;
            else if (is_pulse) state_next = ST_PMUL;
          end else if (is_chaser && !fast) begin
            state_next = ST_MOD;
          end
        end
      end
      ST_CHASE: state_next = ST_IDLE;
      ST_PMUL:  state_next = ST_PDIV;
      ST_PDIV:  state_next = ST_IDLE;
      ST_MOD: begin
        if (mod_cnt == 4'd8) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!q_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != ST_IDLE) || q_full;
    q_push = 1'b0;
    q_job  = '0;
    case (state)
      ST_IDLE: begin
        q_push = accept && action && (!is_chaser || fast);
        q_job  = '{idx: pixel_index, red: red_in, green: green_in, blue: blue_in,
                   bright: bright_now};
      end
      ST_PUSH: begin
        q_push = !q_full;
        q_job  = '{idx: hold_idx, red: hold_r, green: hold_g, blue: hold_b,
                   bright: ({1'b0, mod_rem} < {1'b0, cfg.spot_width})
                           ? cfg.max_brightness : cfg.min_brightness};
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      rotation_phase   <= '0;
      pixel_offset     <= '0;
      frame_brightness <= FULL_BRIGHT;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept && !action && is_chaser)
            rotation_phase <= rotation_phase + cfg.rotation_step;
        end
        ST_CHASE: pixel_offset <= ofs_prod[23:16];
        ST_PDIV: frame_brightness <= pulse_up ? (cfg.min_brightness + q)
                                              : (cfg.min_brightness - q);
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pulse_addr <= tp[23:16];
        mod_sum    <= sum;
        mod_rem    <= '0;
        mod_cnt    <= '0;
        hold_idx   <= pixel_index;
        hold_r     <= red_in;
        hold_g     <= green_in;
        hold_b     <= blue_in;
      end
      ST_PMUL: begin
        pulse_prod <= {8'd0, sine_val} * {8'd0, dif};
        pulse_up   <= cfg.max_brightness >= cfg.min_brightness;
      end
      ST_MOD: begin
        mod_rem <= rem_step[8:0];
        mod_sum <= {mod_sum[7:0], 1'b0};
        mod_cnt <= mod_cnt + 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/lrfe_fifo.sv */
// lrfe_fifo: short job queue between the front and the back
// depends on lrfe_pkg for the job type and depth
module lrfe_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  lrfe_pkg::lrfe_job_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output lrfe_pkg::lrfe_job_t rd_data,
  output logic                empty
);
  import lrfe_pkg::*;

  lrfe_job_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 do_wr, do_rd;

  assign full    = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

/* sv/lrfe_back.sv */
// lrfe_back: scales queued pixel colors by their brightness, holds the result register
// depends on lrfe_pkg; reads from lrfe_fifo
module lrfe_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  lrfe_pkg::lrfe_job_t q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          pixel_out_index,
  output logic [7:0]          red_out,
  output logic [7:0]          green_out,
  output logic [7:0]          blue_out
);
  import lrfe_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_idx;
  logic [15:0] s1_r, s1_g, s1_b;
  logic        out_valid;
  logic        s2_load, s1_ready;

  assign s2_load  = s1_valid && (!out_valid || pop);
  assign s1_ready = !s1_valid || s2_load;
  assign q_pop    = !q_empty && s1_ready;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= q_pop;
      if (s2_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_idx <= q_data.idx;
      s1_r   <= {8'd0, q_data.red}   * {8'd0, q_data.bright};
      s1_g   <= {8'd0, q_data.green} * {8'd0, q_data.bright};
      s1_b   <= {8'd0, q_data.blue}  * {8'd0, q_data.bright};
    end
    if (s2_load) begin
      pixel_out_index <= s1_idx;
      red_out         <= div255(s1_r);
      green_out       <= div255(s1_g);
      blue_out        <= div255(s1_b);
    end
  end

endmodule

/* sv/led_ring_effect_engine_unit.sv */
// pixel path: job queue, multiply register, result register; a pixel whose rotated
// position wraps more than once first runs the slow modulo in the front
// throughput: one pixel per cycle unless the queue, result side or modulo stalls;
// frame transfers hold full during the chaser offset multiply or pulse sine/divide steps
// reset (rst, synchronous): registers to defaults, rotation and offset to zero,
// frame brightness to full, queue and result register emptied
module led_ring_effect_engine_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [31:0] time_ms,
  input  logic [7:0]  pixel_index,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pixel_out_index,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out
);
  import lrfe_pkg::*;

  lrfe_cfg_t cfg;
  lrfe_job_t job_in, job_out;
  logic      jq_push, jq_full, jq_pop, jq_empty;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= RST_MODE;
      cfg.led_count      <= RST_LED_COUNT;
      cfg.spot_width     <= RST_SPOT_WIDTH;
      cfg.rotation_step  <= RST_ROTATION_STEP;
      cfg.pulse_rate     <= RST_PULSE_RATE;
      cfg.max_brightness <= RST_MAX_BRIGHT;
      cfg.min_brightness <= RST_MIN_BRIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODE:          cfg.mode           <= cfg_data[1:0];
        CFG_LED_COUNT:     cfg.led_count      <= cfg_data[8:0];
        CFG_SPOT_WIDTH:    cfg.spot_width     <= cfg_data[8:0];
        CFG_ROTATION_STEP: cfg.rotation_step  <= cfg_data[15:0];
        CFG_PULSE_RATE:    cfg.pulse_rate     <= cfg_data[23:0];
        CFG_MAX_BRIGHT:    cfg.max_brightness <= cfg_data[7:0];
        CFG_MIN_BRIGHT:    cfg.min_brightness <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // front: frame updates and per-pixel brightness, in transfer order
  lrfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .action      (action),
    .time_ms     (time_ms),
    .pixel_index (pixel_index),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .q_full      (jq_full),
    .q_push      (jq_push),
    .q_job       (job_in)
  );

  // job queue decouples classification from scaling
  lrfe_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (jq_push),
    .wr_data (job_in),
    .full    (jq_full),
    .rd_en   (jq_pop),
    .rd_data (job_out),
    .empty   (jq_empty)
  );

  // back: multiply, divide by 255, result register
  lrfe_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (jq_empty),
    .q_data          (job_out),
    .q_pop           (jq_pop),
    .empty           (empty),
    .pop             (pop),
    .pixel_out_index (pixel_out_index),
    .red_out         (red_out),
    .green_out       (green_out),
    .blue_out        (blue_out)
  );

endmodule

/* sv/lrfe_checker.sv */
// lrfe_checker: port-level assertions for the led ring effect engine
// depends on the top level's ports only; attached by the bind at the end
module lrfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] pixel_out_index,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out
);

  // reset leaves the block ready with nothing to deliver
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not ready and empty after reset");

  // empty stays high after reset until a first item has passed the queue and scaling stages
  a_min_latency: assert property (@(posedge clk) rst |=> (empty [*2]))
    else $error("result appeared too soon after reset");

  // a waiting result is not lost while it is not taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> ($stable(pixel_out_index) && $stable(red_out)
                            && $stable(green_out) && $stable(blue_out)))
    else $error("waiting result changed");

endmodule

bind led_ring_effect_engine_unit lrfe_checker u_lrfe_checker (.*);

/* tb/sv/tb.sv */
// tb: self-checking testbench for led_ring_effect_engine_unit, fixed, chaser and pulse effects
// depends on lrfe_pkg (codes, register layout, sine quarter wave) and the engine top level
module tb;
  import lrfe_pkg::*;

  // item kinds on the action port
  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;
  // the one effect code the package leaves unnamed, behaves like fixed
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // quiet cycles after the last result before touching registers or ending
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = CFG_MODE;
  logic [23:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic        action = ACT_FRAME;
  logic [31:0] time_ms = '0;
  logic [7:0]  pixel_index = '0;
  logic [7:0]  red_in = '0;
  logic [7:0]  green_in = '0;
  logic [7:0]  blue_in = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  pixel_out_index;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;

  led_ring_effect_engine_unit uut (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .push, .full, .action, .time_ms, .pixel_index, .red_in, .green_in, .blue_in,
    .empty, .pop, .pixel_out_index, .red_out, .green_out, .blue_out
  );

  always #6 clk = ~clk;

  // mirror of the register file, starts at the reset values
  lrfe_cfg_t regs = '{RST_MODE, RST_LED_COUNT, RST_SPOT_WIDTH, RST_ROTATION_STEP,
                      RST_PULSE_RATE, RST_MAX_BRIGHT, RST_MIN_BRIGHT};
  // mirror of the per-frame state
  logic [15:0] rotation = '0;
  logic [7:0]  offset = '0;
  logic [7:0]  pulse_level = FULL_BRIGHT;

  rgb_pixel_t expected_pixels[$];
  bit         failed = 1'b0;
  bit         send_gaps = 1'b1;
  bit         pop_stalls = 1'b1;
  int         pop_hold = 0;

  // ring size as the engine sees it: 0 means 1, anything above the max is the max
  function automatic int unsigned ring_of(logic [8:0] count);
    if (count == 9'd0) return 1;
    if (count > 9'(MAX_LEDS)) return MAX_LEDS;
    return count;
  endfunction

  // raised sine over one turn of an 8-bit phase, built from the quarter wave
  function automatic int unsigned raised_sine(logic [7:0] addr);
    int unsigned j;
    int unsigned h;
    j = addr[6:0];
    h = (j <= 64) ? QUARTER_SINE[j] : QUARTER_SINE[128 - j];
    return addr[7] ? (255 - h) >> 1 : (255 + h) >> 1;
  endfunction

  function automatic logic [7:0] dim(logic [7:0] c, int unsigned level);
    return 8'((int'(c) * level) / 255);
  endfunction

  // frame start: chaser moves the spot, pulse picks this frame's brightness
  function automatic void advance_frame(logic [31:0] stamp);
    int unsigned n;
    int unsigned s;
    int unsigned hi;
    int unsigned lo;
    logic [63:0] product;
    n = ring_of(regs.led_count);
    if (regs.mode == MODE_CHASER) begin
      rotation = rotation + regs.rotation_step;
      offset = 8'((int'(rotation) * n) >> 16);
    end else if (regs.mode == MODE_PULSE) begin
      product = 64'(stamp) * 64'(regs.pulse_rate);
      s = raised_sine(product[23:16]);
      hi = regs.max_brightness;
      lo = regs.min_brightness;
      // max below min runs the pulse downward from min
      if (hi >= lo) pulse_level = 8'(lo + (s * (hi - lo)) / 255);
      else pulse_level = 8'(lo - (s * (lo - hi)) / 255);
    end
  endfunction

  function automatic rgb_pixel_t shade_pixel(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                             logic [7:0] b);
    rgb_pixel_t p;
    int unsigned n;
    int unsigned level;
    n = ring_of(regs.led_count);
    p = '{idx, r, g, b};
    if (regs.mode == MODE_CHASER || regs.mode == MODE_PULSE) begin
      // chaser position wraps around the ring however far the index runs past it
      if (regs.mode == MODE_CHASER)
        level = ((int'(idx) + int'(offset)) % n < int'(regs.spot_width)) ?
                regs.max_brightness : regs.min_brightness;
      else
        level = pulse_level;
      p.red = dim(r, level);
      p.green = dim(g, level);
      p.blue = dim(b, level);
    end
    return p;
  endfunction

  // input side: predict at every transfer into the engine
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      if (action == ACT_FRAME) advance_frame(time_ms);
      else expected_pixels.push_back(shade_pixel(pixel_index, red_in, green_in, blue_in));
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // result side: every transfer out is compared with the oldest expected pixel
  always @(posedge clk) begin
    rgb_pixel_t want;
    if (!rst && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual idx %0d rgb %0d %0d %0d",
                 $time, pixel_out_index, red_out, green_out, blue_out);
        failed = 1'b1;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_out_index", want.idx, pixel_out_index);
        check_field("red_out", want.red, red_out);
        check_field("green_out", want.green, green_out);
        check_field("blue_out", want.blue, blue_out);
      end
    end
  end

  // receiver: pop stalls in random bursts while stalls are enabled
  always @(posedge clk) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (pop_stalls && $urandom_range(0, 9) == 0) begin
      pop_hold <= $urandom_range(0, 12);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // one transfer into the engine; push stays high unless a gap follows
  task automatic send_item(logic act, logic [31:0] stamp, logic [7:0] idx, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b);
    push <= 1'b1;
    action <= act;
    time_ms <= stamp;
    pixel_index <= idx;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (full);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_pixel(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_item(ACT_PIXEL, $urandom, idx, r, g, b);
  endtask

  task automatic send_frame(logic [31:0] stamp);
    send_item(ACT_FRAME, stamp, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // stop sending, let every expected pixel come out, then let frame work finish
  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // registers only change while the engine is idle
  task automatic apply_settings(lrfe_cfg_t c);
    logic [23:0] value [7];
    drain();
    value = '{24'(c.mode), 24'(c.led_count), 24'(c.spot_width), 24'(c.rotation_step),
              24'(c.pulse_rate), 24'(c.max_brightness), 24'(c.min_brightness)};
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= value[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    regs = c;
  endtask

  function automatic logic [7:0] rand_level;
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic lrfe_cfg_t pick_settings(logic [1:0] m, bit corner);
    lrfe_cfg_t c;
    c.mode = m;
    c.led_count = 9'($urandom_range(1, 64));
    c.spot_width = 9'($urandom_range(0, 40));
    c.rotation_step = 16'($urandom);
    c.pulse_rate = $urandom_range(0, 1) ? 24'($urandom_range(0, 5000)) : 24'($urandom);
    c.max_brightness = rand_level();
    c.min_brightness = rand_level();
    if (corner) begin
      case ($urandom_range(0, 3))
        0: c.led_count = 9'd0;
        1: c.led_count = 9'd256;
        2: c.led_count = 9'd511;
        default: c.led_count = 9'd1;
      endcase
      c.spot_width = $urandom_range(0, 1) ? 9'd0 : 9'd511;
      c.rotation_step = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      c.pulse_rate = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      c.max_brightness = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      c.min_brightness = ~c.max_brightness;
    end
    return c;
  endfunction

  // fixed mode straight after reset, no register written yet
  task automatic test_passthrough;
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_frame(32'hFFFF_FFFF);
    send_pixel(8'h5A, 8'hA5, 8'h5A, 8'hC3);
  endtask

  // spot at the ring edges, index far past the ring, empty ring and oversized spot
  task automatic test_chaser_corners;
    apply_settings('{MODE_CHASER, 9'd24, 9'd4, 16'hFFFF, RST_PULSE_RATE, 8'd255, 8'd0});
    send_frame(32'd0);
    send_pixel(8'd0, 8'd255, 8'd128, 8'd1);
    send_pixel(8'd23, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd200, 8'd100, 8'd50);
    send_frame(32'd0);
    send_pixel(8'd3, 8'd255, 8'd255, 8'd255);
    // ring of zero acts as one, spot wider than the ring lights everything
    apply_settings('{MODE_CHASER, 9'd0, 9'd511, 16'd777, RST_PULSE_RATE, 8'd77, 8'd200});
    send_pixel(8'd9, 8'd255, 8'd0, 8'd255);
    send_frame(32'd5);
    send_pixel(8'd128, 8'd99, 8'd255, 8'd3);
  endtask

  // inverted range, full phase rate, zero and top time stamps
  task automatic test_pulse_corners;
    apply_settings('{MODE_PULSE, 9'd24, 9'd4, 16'd1, 24'hFFFFFF, 8'd0, 8'd255});
    send_frame(32'd0);
    send_pixel(8'd1, 8'd255, 8'd255, 8'd255);
    send_frame(32'hFFFF_FFFF);
    send_pixel(8'd2, 8'd255, 8'd127, 8'd0);
    apply_settings('{MODE_PULSE, 9'd511, 9'd0, 16'd1, RST_PULSE_RATE, 8'd255, 8'd0});
    send_frame(32'd1234);
    send_pixel(8'd200, 8'd255, 8'd255, 8'd255);
  endtask

  // unused effect code passes through; back to pulse without a frame keeps old brightness
  task automatic test_mode_switch;
    apply_settings('{MODE_SPARE, 9'd511, 9'd0, 16'd1, RST_PULSE_RATE, 8'd255, 8'd0});
    send_pixel(8'd7, 8'd17, 8'd255, 8'd1);
    apply_settings('{MODE_PULSE, 9'd64, 9'd3, 16'd1, 24'd99, 8'd10, 8'd20});
    send_pixel(8'd8, 8'd255, 8'd255, 8'd255);
  endtask

  // frames followed by runs of pixels around the ring, a few stray indexes
  task automatic send_effect_stream(int quota);
    int unsigned n;
    int unsigned start;
    int          burst;
    int          sent;
    logic [31:0] stamp;
    logic [7:0]  idx;
    n = ring_of(regs.led_count);
    stamp = $urandom;
    sent = 0;
    while (sent < quota) begin
      stamp = $urandom_range(0, 7) == 0 ? 32'($urandom) : stamp + $urandom_range(1, 40);
      send_frame(stamp);
      sent++;
      burst = $urandom_range(1, n < 32 ? n : 32);
      // the last run is cut so the stream ends on its quota
      if (burst > quota - sent) burst = quota - sent;
      start = $urandom_range(0, n - 1);
      for (int k = 0; k < burst; k++) begin
        idx = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'((start + k) % n);
        send_pixel(idx, rand_level(), rand_level(), rand_level());
        sent++;
      end
    end
  endtask

  // several settings, corners on every other one, idling switched on and off
  task automatic test_random_mix;
    logic [1:0] order [4] = '{MODE_CHASER, MODE_PULSE, MODE_FIXED, MODE_SPARE};
    for (int phase = 0; phase < 7; phase++) begin
      apply_settings(pick_settings(order[phase % 4], phase % 2 == 1));
      send_gaps = $urandom_range(0, 3) != 0;
      pop_stalls = $urandom_range(0, 3) != 0;
      send_effect_stream(40);
      // sender holds off once until the pipe is empty, then resumes
      if (phase == 3) drain();
      send_effect_stream(40);
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream;
    apply_settings(pick_settings(MODE_CHASER, 1'b0));
    send_gaps = 1'b0;
    pop_stalls = 1'b0;
    send_effect_stream(45);
    apply_settings(pick_settings(MODE_PULSE, 1'b0));
    send_effect_stream(45);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_passthrough();
    test_chaser_corners();
    test_pulse_corners();
    test_mode_switch();
    test_random_mix();
    test_steady_stream();
    drain();
    if (!failed) $display("** led_ring_effect_engine_unit: PASSED **");
    else $display("** led_ring_effect_engine_unit: FAILED **");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(12 * 400000);
    $display("%0t: timeout, %0d results still expected", $time, expected_pixels.size());
    $display("** led_ring_effect_engine_unit: FAILED **");
    $finish;
  end

endmodule
